FILE: rtl/tsac_pkg.sv
// ----------------------------------------------------------------------------
// tsac_pkg
// Shared types and constants for the two-sensor axle counter.
// ----------------------------------------------------------------------------
package tsac_pkg;

  // Number of tracks held in the state memory
  localparam int TRACKS = 2;
  localparam int TRK_AW = (TRACKS > 1) ? $clog2(TRACKS) : 1;

  // Stream widths (fields packed from bit 0, tdata padded to whole bytes)
  localparam int IN_DATA_W  = 40;  // sensor(1) stamp(32) pad(7)
  localparam int IN_USER_W  = 2;   // op(1) track(1)
  localparam int OUT_DATA_W = 120; // axle(16) entr(32) exit(32) latest(32) phase(3) pad(5)

  localparam logic [15:0] AXLE_MAX = 16'hFFFF;

  // Item kinds carried in tuser
  localparam logic OP_HIT   = 1'b0;
  localparam logic OP_CLEAR = 1'b1;

  // Track phase codes
  typedef enum logic [2:0] {
    PH_IDLE    = 3'd0,
    PH_TIME_A  = 3'd1,
    PH_COUNT_A = 3'd2,
    PH_TIME_B  = 3'd3,
    PH_COUNT_B = 3'd4
  } phase_e;

  // One track's state, one memory word
  typedef struct packed {
    phase_e      phase;
    logic [15:0] axles;
    logic [31:0] first_stamp;
    logic [31:0] last_stamp;
    logic [31:0] entry_gap;
    logic [31:0] exit_gap;
  } entry_t;

endpackage

FILE: rtl/two_sensor_axle_counter.sv
// ----------------------------------------------------------------------------
// two_sensor_axle_counter
// Per-track axle counter: sensor hits and clears update one word of a
// track state memory and return the track's updated counters.
// ----------------------------------------------------------------------------
// An accepted item waits in stage 1; its result then goes to the output register.
// Throughput: one item per cycle while the result stream is not stalled; the
//   state memory is read on acceptance and written as the item leaves stage 1,
//   with a bypass register for back-to-back items on the same track.
// Reset: all tracks read as idle with zero counters (per-track valid bits);
//   no clearing pass, the block is ready straight after reset.
module two_sensor_axle_counter (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  // Input stream
  input  logic                           s_axis_tvalid_i,
  output logic                           s_axis_tready_o,
  input  logic [tsac_pkg::IN_DATA_W-1:0] s_axis_tdata_i,  // sensor, stamp
  input  logic [tsac_pkg::IN_USER_W-1:0] s_axis_tuser_i,  // op, track
  // Result stream
  output logic                            m_axis_tvalid_o,
  input  logic                            m_axis_tready_i,
  output logic [tsac_pkg::OUT_DATA_W-1:0] m_axis_tdata_o  // axle_total,
                                          // entrance_delta, exit_delta,
                                          // latest_stamp, phase
);
  import tsac_pkg::*;

  // Input field split
  logic              in_op, in_track, in_sensor;
  logic [31:0]       in_stamp;
  logic              in_xfer;
  logic [TRK_AW-1:0] in_addr;

  assign in_op     = s_axis_tuser_i[0];
  assign in_track  = s_axis_tuser_i[1];
  assign in_sensor = s_axis_tdata_i[0];
  assign in_stamp  = s_axis_tdata_i[32:1];
  assign in_addr   = TRK_AW'(in_track);

  // Stage 1 (item waiting on its memory read) and output register
  logic              s1_vld_q;
  logic              s1_op_q, s1_sensor_q, s1_range_q;
  logic [TRK_AW-1:0] s1_addr_q;
  logic [31:0]       s1_stamp_q;
  logic              out_vld_q;
  logic [OUT_DATA_W-1:0] out_data_q, out_data_d;
  logic              advance;

  assign advance         = s1_vld_q && (!out_vld_q || m_axis_tready_i);
  assign s_axis_tready_o = !s1_vld_q || advance;
  assign in_xfer         = s_axis_tvalid_i && s_axis_tready_o;

  // Track state memory with a registered read
  entry_t mem_q [TRACKS];
  entry_t rd_q;
  entry_t byp_q;
  logic [TRK_AW-1:0] byp_addr_q;
  logic              byp_vld_q;
  logic [TRACKS-1:0] wr_vld_q;
  entry_t cur, nxt;
  logic   wr_en;

  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      rd_q <= mem_q[in_addr];
    end
    if (wr_en) begin
      mem_q[s1_addr_q] <= nxt;
    end
  end

  // Current word: latest write wins, unwritten entries read as reset state
  always_comb begin
    if (byp_vld_q && (byp_addr_q == s1_addr_q)) begin
      cur = byp_q;
    end else if (wr_vld_q[s1_addr_q]) begin
      cur = rd_q;
    end else begin
      cur = '0;
    end
  end

  // Update of one track
  always_comb begin
    phase_e lead_time, lead_count, trail_time, trail_count;
    lead_time   = s1_sensor_q ? PH_TIME_B  : PH_TIME_A;
    lead_count  = s1_sensor_q ? PH_COUNT_B : PH_COUNT_A;
    trail_time  = s1_sensor_q ? PH_TIME_A  : PH_TIME_B;
    trail_count = s1_sensor_q ? PH_COUNT_A : PH_COUNT_B;
    nxt = cur;
    if (s1_op_q == OP_CLEAR) begin
      nxt = '0;
    end else if ((cur.phase == lead_time) || (cur.phase == lead_count)) begin
      if (cur.axles != AXLE_MAX) nxt.axles = cur.axles + 16'd1;
      nxt.last_stamp = s1_stamp_q;
    end else if (cur.phase == trail_time) begin
      nxt.entry_gap = s1_stamp_q - cur.first_stamp;
      nxt.phase     = trail_count;
    end else if (cur.phase == trail_count) begin
      nxt.exit_gap = s1_stamp_q - cur.last_stamp;
    end else begin
      // idle track: this sensor leads
      if (cur.axles != AXLE_MAX) nxt.axles = cur.axles + 16'd1;
      nxt.last_stamp  = s1_stamp_q;
      nxt.first_stamp = s1_stamp_q;
      nxt.phase       = lead_time;
    end
  end

  assign wr_en = advance && s1_range_q;

  // Result word; out-of-range tracks report all zero
  always_comb begin
    out_data_d = '0;
    if (s1_range_q) begin
      out_data_d[15:0]    = nxt.axles;
      out_data_d[47:16]   = nxt.entry_gap;
      out_data_d[79:48]   = nxt.exit_gap;
      out_data_d[111:80]  = nxt.last_stamp;
      out_data_d[114:112] = nxt.phase;
    end
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
      byp_vld_q <= 1'b0;
      wr_vld_q  <= '0;
    end else begin
      if (in_xfer) begin
        s1_vld_q <= 1'b1;
      end else if (advance) begin
        s1_vld_q <= 1'b0;
      end
      if (advance) begin
        out_vld_q <= 1'b1;
      end else if (m_axis_tready_i) begin
        out_vld_q <= 1'b0;
      end
      if (wr_en) begin
        byp_vld_q           <= 1'b1;
        wr_vld_q[s1_addr_q] <= 1'b1;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      s1_op_q     <= in_op;
      s1_sensor_q <= in_sensor;
      s1_stamp_q  <= in_stamp;
      s1_addr_q   <= in_addr;
      s1_range_q  <= (32'(in_track) < TRACKS);
    end
    if (wr_en) begin
      byp_q      <= nxt;
      byp_addr_q <= s1_addr_q;
    end
    if (advance) begin
      out_data_q <= out_data_d;
    end
  end

  assign m_axis_tvalid_o = out_vld_q;
  assign m_axis_tdata_o  = out_data_q;

endmodule

FILE: rtl/tsac_checker.sv
// ----------------------------------------------------------------------------
// tsac_checker
// Port-level checks for the two-sensor axle counter, bound to the top level.
// ----------------------------------------------------------------------------
module tsac_checker (
  input logic                            clk_i,
  input logic                            rst_ni,
  input logic                            s_axis_tready_o,
  input logic                            m_axis_tvalid_o,
  input logic                            m_axis_tready_i,
  input logic [tsac_pkg::OUT_DATA_W-1:0] m_axis_tdata_o
);
  import tsac_pkg::*;

  logic [2:0] ph;
  assign ph = m_axis_tdata_o[114:112];

  // Stalled result holds its payload
  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && !m_axis_tready_i) |=> $stable(m_axis_tdata_o))
    else $error("result changed while stalled");

  // Input side only stalls behind a blocked result
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready_o |-> (m_axis_tvalid_o && !m_axis_tready_i))
    else $error("input stalled without output back-pressure");

  // Idle track reports no axles and no stamp
  a_idle_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && (ph == PH_IDLE)) |->
      ((m_axis_tdata_o[15:0] == 16'd0) && (m_axis_tdata_o[111:80] == 32'd0)))
    else $error("idle track with non-zero values");

  // Timing phase: at least one axle, no deltas yet
  a_timing: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && ((ph == PH_TIME_A) || (ph == PH_TIME_B))) |->
      ((m_axis_tdata_o[15:0] != 16'd0) && (m_axis_tdata_o[79:16] == 64'd0)))
    else $error("timing phase with bad counters");

  // Counting phase has counted at least one axle
  a_counting: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && ((ph == PH_COUNT_A) || (ph == PH_COUNT_B))) |->
      (m_axis_tdata_o[15:0] != 16'd0))
    else $error("counting phase without axles");

endmodule

bind two_sensor_axle_counter tsac_checker u_tsac_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .s_axis_tready_o (s_axis_tready_o),
  .m_axis_tvalid_o (m_axis_tvalid_o),
  .m_axis_tready_i (m_axis_tready_i),
  .m_axis_tdata_o  (m_axis_tdata_o)
);

FILE: sim/two_sensor_axle_counter_tb.sv
// ----------------------------------------------------------------------------
// two_sensor_axle_counter_tb
// Self-checking bench for the per-track axle counter. Sensor hits and track
// clears go in on the input stream; a behavioural copy of every track's state
// predicts each readout, and a monitor compares each result transfer field by
// field. Directed sequences and random traffic under several idle and
// back-pressure mixes.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module two_sensor_axle_counter_tb;
  import tsac_pkg::*;

  localparam int IDLE_LIMIT  = 5000; // cycles without any transfer
  localparam int DRAIN_TICKS = 8;

  // One readout of a track, as carried on the result stream
  typedef struct packed {
    logic [15:0] axles;
    logic [31:0] entry_gap;
    logic [31:0] exit_gap;
    logic [31:0] latest;
    logic [2:0]  phase;
  } readout_t;

  logic                  clk_i = 1'b0;
  logic                  rst_ni = 1'b0;
  logic                  s_axis_tvalid_i = 1'b0;
  logic                  s_axis_tready_o;
  logic [IN_DATA_W-1:0]  s_axis_tdata_i = '0;  // sensor, stamp, pad
  logic [IN_USER_W-1:0]  s_axis_tuser_i = '0;  // op, track
  logic                  m_axis_tvalid_o;
  logic                  m_axis_tready_i = 1'b0;
  logic [OUT_DATA_W-1:0] m_axis_tdata_o;   // axle_total, entrance_delta,
                                           // exit_delta, latest_stamp, phase

  // Track state mirror
  phase_e      trk_phase [TRACKS];
  logic [15:0] trk_axles [TRACKS];
  logic [31:0] trk_first [TRACKS];
  logic [31:0] trk_last  [TRACKS];
  logic [31:0] trk_entry [TRACKS];
  logic [31:0] trk_exit  [TRACKS];

  readout_t    pending_readouts[$];
  int unsigned mismatch_cnt = 0;
  int unsigned send_idle_pct = 0;
  int unsigned recv_stall_pct = 0;
  int unsigned quiet_cycles = 0;

  // Random stimulus bookkeeping: per-track clock and preferred leading sensor
  logic [31:0] trk_clock [TRACKS];
  logic        trk_lead  [TRACKS];

  two_sensor_axle_counter dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .s_axis_tuser_i  (s_axis_tuser_i),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o)
  );

  initial begin
    forever #6 clk_i = ~clk_i;
  end

  // Apply one item to the mirrored state and return the track's readout
  function automatic readout_t track_update(logic op, logic [TRK_AW-1:0] t, logic sensor,
                                            logic [31:0] stamp);
    phase_e   lead_time, lead_count, trail_time, trail_count;
    readout_t r;
    r = '0;
    if (32'(t) >= TRACKS) return r;
    lead_time   = sensor ? PH_TIME_B  : PH_TIME_A;
    lead_count  = sensor ? PH_COUNT_B : PH_COUNT_A;
    trail_time  = sensor ? PH_TIME_A  : PH_TIME_B;
    trail_count = sensor ? PH_COUNT_A : PH_COUNT_B;
    if (op == OP_CLEAR) begin
      trk_phase[t] = PH_IDLE;
      trk_axles[t] = '0;
      trk_first[t] = '0;
      trk_last[t]  = '0;
      trk_entry[t] = '0;
      trk_exit[t]  = '0;
    end else if (trk_phase[t] == lead_time || trk_phase[t] == lead_count) begin
      if (trk_axles[t] != AXLE_MAX) trk_axles[t] = trk_axles[t] + 16'd1;
      trk_last[t] = stamp;
    end else if (trk_phase[t] == trail_time) begin
      trk_entry[t] = stamp - trk_first[t];
      trk_phase[t] = trail_count;
    end else if (trk_phase[t] == trail_count) begin
      trk_exit[t] = stamp - trk_last[t];
    end else begin
      // idle: the sensor that fires first leads
      if (trk_axles[t] != AXLE_MAX) trk_axles[t] = trk_axles[t] + 16'd1;
      trk_last[t]  = stamp;
      trk_first[t] = stamp;
      trk_phase[t] = lead_time;
    end
    r.axles     = trk_axles[t];
    r.entry_gap = trk_entry[t];
    r.exit_gap  = trk_exit[t];
    r.latest    = trk_last[t];
    r.phase     = trk_phase[t];
    return r;
  endfunction

  // Send one item; called and returns at a falling edge
  task automatic send_item(logic op, logic [TRK_AW-1:0] trk, logic sensor,
                           logic [31:0] stamp);
    while ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid_i <= 1'b0;
      @(negedge clk_i);
    end
    s_axis_tvalid_i <= 1'b1;
    s_axis_tdata_i  <= {{(IN_DATA_W-33){1'b0}}, stamp, sensor};
    s_axis_tuser_i  <= {trk, op};
    do @(posedge clk_i); while (!s_axis_tready_o);
    pending_readouts.push_back(track_update(op, trk, sensor, stamp));
    @(negedge clk_i);
  endtask

  // Receiver back-pressure
  always @(negedge clk_i) begin
    m_axis_tready_i <= ($urandom_range(99) >= recv_stall_pct);
  end

  // Result checker
  always @(posedge clk_i) begin : check_results
    readout_t want, got;
    if (rst_ni && m_axis_tvalid_o && m_axis_tready_i) begin
      got.axles     = m_axis_tdata_o[15:0];
      got.entry_gap = m_axis_tdata_o[47:16];
      got.exit_gap  = m_axis_tdata_o[79:48];
      got.latest    = m_axis_tdata_o[111:80];
      got.phase     = m_axis_tdata_o[114:112];
      if (pending_readouts.size() == 0) begin
        $error("result transfer with nothing outstanding: tdata %h", m_axis_tdata_o);
        mismatch_cnt++;
      end else begin
        want = pending_readouts.pop_front();
        if (got.axles !== want.axles) begin
          $error("axle_total: expected %0d, got %0d", want.axles, got.axles);
          mismatch_cnt++;
        end
        if (got.entry_gap !== want.entry_gap) begin
          $error("entrance_delta: expected %0d, got %0d", want.entry_gap, got.entry_gap);
          mismatch_cnt++;
        end
        if (got.exit_gap !== want.exit_gap) begin
          $error("exit_delta: expected %0d, got %0d", want.exit_gap, got.exit_gap);
          mismatch_cnt++;
        end
        if (got.latest !== want.latest) begin
          $error("latest_stamp: expected %0d, got %0d", want.latest, got.latest);
          mismatch_cnt++;
        end
        if (got.phase !== want.phase) begin
          $error("phase: expected %0d, got %0d", want.phase, got.phase);
          mismatch_cnt++;
        end
      end
    end
  end

  // Watchdog: too long without any transfer on either side
  always @(posedge clk_i) begin
    if ((s_axis_tvalid_i && s_axis_tready_o) || (m_axis_tvalid_o && m_axis_tready_i))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= IDLE_LIMIT) begin
      $display("two_sensor_axle_counter_tb NOT OK");
      $finish;
    end
  end

  // Hand-picked sequences: both directions, wrapping deltas, clears
  task automatic test_directed();
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    // direction A on track 0, stamps at both extremes
    send_item(OP_HIT, 1'b0, 1'b0, 32'h0000_0000);
    send_item(OP_HIT, 1'b0, 1'b0, 32'hFFFF_FFFF);
    send_item(OP_HIT, 1'b0, 1'b1, 32'h0000_000A);  // trailing while timing
    send_item(OP_HIT, 1'b0, 1'b1, 32'h0000_0005);  // exit delta wraps
    send_item(OP_HIT, 1'b0, 1'b0, 32'h0000_0064);
    send_item(OP_HIT, 1'b0, 1'b1, 32'h0000_0000);
    // direction B on track 1, interleaved with track 0
    send_item(OP_HIT, 1'b1, 1'b1, 32'hFFFF_FFF0);
    send_item(OP_HIT, 1'b0, 1'b0, 32'h7FFF_FFFF);
    send_item(OP_HIT, 1'b1, 1'b0, 32'h0000_0020);  // entrance delta wraps
    send_item(OP_HIT, 1'b1, 1'b0, 32'h0000_0025);
    send_item(OP_HIT, 1'b1, 1'b1, 32'h8000_0000);
    // clear ignores sensor and stamp; clear of an idle track
    send_item(OP_CLEAR, 1'b0, 1'b1, 32'hFFFF_FFFF);
    send_item(OP_CLEAR, 1'b0, 1'b0, 32'h0000_0000);
    send_item(OP_HIT, 1'b0, 1'b1, 32'hAAAA_AAAA);
    send_item(OP_HIT, 1'b0, 1'b1, 32'h5555_5555);
    send_item(OP_HIT, 1'b0, 1'b0, 32'h5555_5555);
    send_item(OP_HIT, 1'b0, 1'b0, 32'h5555_5556);
    send_item(OP_CLEAR, 1'b1, 1'b0, 32'h0000_0000);
    send_item(OP_HIT, 1'b1, 1'b0, 32'h1234_5678);
    send_item(OP_CLEAR, 1'b1, 1'b1, 32'h1234_5678);
    send_item(OP_CLEAR, 1'b0, 1'b1, 32'h0000_0001);
  endtask

  // Mostly train-like sequences per track with random content, some noise
  task automatic test_random(int unsigned n_items, int unsigned idle_pct,
                             int unsigned stall_pct);
    logic [TRK_AW-1:0] t;
    logic              op, sensor;
    logic [31:0]       stamp;
    send_idle_pct  = idle_pct;
    recv_stall_pct = stall_pct;
    for (int unsigned i = 0; i < n_items; i++) begin
      t  = TRK_AW'($urandom_range(TRACKS - 1));
      op = ($urandom_range(99) < 5) ? OP_CLEAR : OP_HIT;
      if (op == OP_CLEAR) trk_lead[t] = 1'($urandom_range(1));
      sensor = ($urandom_range(99) < 65) ? trk_lead[t] : ~trk_lead[t];
      if ($urandom_range(99) < 10) begin
        stamp = $urandom;
      end else begin
        trk_clock[t] = trk_clock[t] + $urandom_range(1, 5000);
        stamp = trk_clock[t];
      end
      send_item(op, t, sensor, stamp);
    end
  endtask

  initial begin
    for (int t = 0; t < TRACKS; t++) begin
      trk_phase[t] = PH_IDLE;
      trk_axles[t] = '0;
      trk_first[t] = '0;
      trk_last[t]  = '0;
      trk_entry[t] = '0;
      trk_exit[t]  = '0;
      trk_clock[t] = $urandom;
      trk_lead[t]  = 1'($urandom_range(1));
    end
    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    test_directed();
    test_random(382, 0, 0);
    test_random(382, 70, 0);
    test_random(382, 0, 70);
    test_random(382, 9, 9);

    s_axis_tvalid_i <= 1'b0;
    recv_stall_pct = 0;
    while (pending_readouts.size() != 0) @(posedge clk_i);
    repeat (DRAIN_TICKS) @(posedge clk_i);
    if (mismatch_cnt == 0)
      $display("two_sensor_axle_counter_tb OK");
    else
      $display("two_sensor_axle_counter_tb NOT OK");
    $finish;
  end

endmodule

FILE: two_sensor_axle_counter.f
rtl/tsac_pkg.sv
rtl/two_sensor_axle_counter.sv
rtl/tsac_checker.sv
sim/two_sensor_axle_counter_tb.sv
